// File: hw/rtl/qte_pkg.sv
// shared constants, angle table and types for the quaternion to euler converter
package qte_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANG_TAB_LEN      = 24;
   localparam int COMP_W           = 16;
   localparam int OUT_W            = 16;
   localparam int OPND_W           = 34;
   localparam int CORD_W           = 45;
   localparam int ANG_W            = 32;
   localparam int PRESCALE_BITS    = 40;
   localparam int PRESCALE_PASSES  = 6;
   localparam int ISQRT_STAGES     = 32;
   localparam int RAD_W            = 64;

   localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

   // atan(2^-i), pi = 2^31
   localparam logic [ANG_W-1:0] ANG_TAB [ANG_TAB_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic signed [OPND_W-1:0] y;
      logic signed [OPND_W-1:0] x;
   } operand_type;

   function automatic int cordic_latency(int steps);
      return steps + PRESCALE_PASSES + 3;
   endfunction

endpackage

// File: hw/rtl/quaternion_to_euler_top.sv
// quaternion to euler angle converter, fully pipelined
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_comp_w/x/y/z (signed q2.14)
//   rsp     | out       | rsp_valid, rsp_ready, rsp_pitch/roll/heading_angle, rsp_degenerate
//
// one transaction per cycle sustained while rsp is not stalled; the pipeline depth is set
// by the 32-stage square root and the cordic stage chain
// reset clears the valid bits of the pipeline and the skid register only
// a skid register behind the pipeline takes one result when rsp stalls, so a
// new transaction is still accepted in that cycle; the whole pipeline then holds
module quaternion_to_euler_top #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [qte_pkg::COMP_W-1:0] req_comp_w,
   input  logic signed [qte_pkg::COMP_W-1:0] req_comp_x,
   input  logic signed [qte_pkg::COMP_W-1:0] req_comp_y,
   input  logic signed [qte_pkg::COMP_W-1:0] req_comp_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [qte_pkg::OUT_W-1:0]  rsp_pitch_angle,
   output logic signed [qte_pkg::OUT_W-1:0]  rsp_roll_angle,
   output logic signed [qte_pkg::OUT_W-1:0]  rsp_heading_angle,
   output logic                              rsp_degenerate
);
   import qte_pkg::*;

   localparam int CL         = cordic_latency(CORDIC_STEPS);
   localparam int PRE_STAGES = 5 + ISQRT_STAGES;
   localparam int TOTAL      = PRE_STAGES + CL;
   localparam int PW         = 2 * COMP_W;

   typedef struct packed {
      logic signed [OUT_W-1:0] pitch;
      logic signed [OUT_W-1:0] roll;
      logic signed [OUT_W-1:0] heading;
      logic                    degen;
   } result_type;

   typedef struct packed {
      operand_type pitch;
      operand_type heading;
   } pair_type;

   logic enable;
   logic vld_ff   [TOTAL];
   logic degen_ff [TOTAL];

   // whole pipeline moves together unless the skid slot is occupied
   logic skid_vld_ff;
   assign enable    = !skid_vld_ff;
   assign req_ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL; i++) vld_ff[i] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // zero norm only when every component is zero
   always_ff @(posedge clock) begin
      if (enable) begin
         degen_ff[0] <= (req_comp_w == 0) && (req_comp_x == 0) &&
                        (req_comp_y == 0) && (req_comp_z == 0);
         for (int i = 1; i < TOTAL; i++) degen_ff[i] <= degen_ff[i-1];
      end
   end

   // stage 1: squares and cross products
   logic signed [PW-1:0] sw_ff, sx_ff, sy_ff, sz_ff;
   logic signed [PW-1:0] xy_ff, zw_ff, yw_ff, xz_ff, yz_ff, xw_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         sw_ff <= PW'(req_comp_w) * PW'(req_comp_w);
         sx_ff <= PW'(req_comp_x) * PW'(req_comp_x);
         sy_ff <= PW'(req_comp_y) * PW'(req_comp_y);
         sz_ff <= PW'(req_comp_z) * PW'(req_comp_z);
         xy_ff <= PW'(req_comp_x) * PW'(req_comp_y);
         zw_ff <= PW'(req_comp_z) * PW'(req_comp_w);
         yw_ff <= PW'(req_comp_y) * PW'(req_comp_w);
         xz_ff <= PW'(req_comp_x) * PW'(req_comp_z);
         yz_ff <= PW'(req_comp_y) * PW'(req_comp_z);
         xw_ff <= PW'(req_comp_x) * PW'(req_comp_w);
      end
   end

   // stage 2: atan2 operands, half norm and the asin numerator
   pair_type                 pair_in;
   logic signed [OPND_W-1:0] n2_in, h_in;
   logic        [31:0]       d_ff;
   logic signed [OPND_W-1:0] h_ff;
   pair_type                 pair_ff [PRE_STAGES-1];

   always_comb begin
      pair_in.pitch.y   = (OPND_W'(xy_ff) + OPND_W'(zw_ff)) <<< 1;
      pair_in.pitch.x   = OPND_W'(sx_ff) - OPND_W'(sy_ff) - OPND_W'(sz_ff) + OPND_W'(sw_ff);
      pair_in.heading.y = (OPND_W'(yz_ff) + OPND_W'(xw_ff)) <<< 1;
      pair_in.heading.x = OPND_W'(sz_ff) + OPND_W'(sw_ff) - OPND_W'(sx_ff) - OPND_W'(sy_ff);
      n2_in = OPND_W'(sw_ff) + OPND_W'(sx_ff) + OPND_W'(sy_ff) + OPND_W'(sz_ff);
      h_in  = OPND_W'(yw_ff) - OPND_W'(xz_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pair_ff[0] <= pair_in;
         for (int i = 1; i < PRE_STAGES-1; i++) pair_ff[i] <= pair_ff[i-1];
         d_ff <= n2_in[32:1];
         h_ff <= h_in;
      end
   end

   // stage 3: clamp numerator to the half norm
   logic signed [OPND_W-1:0] dext, hc_in;
   logic signed [OPND_W-1:0] hc_ff [PRE_STAGES-2];
   logic        [31:0]       d3_ff;

   always_comb begin
      dext = signed'({2'b00, d_ff});
      if (h_ff > dext) hc_in = dext;
      else if (h_ff < -dext) hc_in = -dext;
      else hc_in = h_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hc_ff[0] <= hc_in;
         for (int i = 1; i < PRE_STAGES-2; i++) hc_ff[i] <= hc_ff[i-1];
         d3_ff <= d_ff;
      end
   end

   // stage 4: squares for the cosine term; stage 5: their difference
   logic signed [OPND_W-1:0] habs;
   logic        [RAD_W-1:0]  dd_ff, hh_ff, rad_ff;
   assign habs = (hc_ff[0] < 0) ? -hc_ff[0] : hc_ff[0];

   always_ff @(posedge clock) begin
      if (enable) begin
         dd_ff  <= RAD_W'(d3_ff) * RAD_W'(d3_ff);
         hh_ff  <= RAD_W'(habs[31:0]) * RAD_W'(habs[31:0]);
         rad_ff <= dd_ff - hh_ff;
      end
   end

   // square root, one result bit per stage
   logic [RAD_W-1:0] sq_v_ff [ISQRT_STAGES];
   logic [RAD_W-1:0] sq_r_ff [ISQRT_STAGES];

   for (genvar j = 0; j < ISQRT_STAGES; j++) begin : g_sqrt
      localparam logic [RAD_W-1:0] BIT =
         {{(RAD_W-1){1'b0}}, 1'b1} << (2 * (ISQRT_STAGES - 1 - j));
      logic [RAD_W-1:0] v_src, r_src, trial;
      if (j == 0) begin : g_first
         assign v_src = rad_ff;
         assign r_src = '0;
      end else begin : g_next
         assign v_src = sq_v_ff[j-1];
         assign r_src = sq_r_ff[j-1];
      end
      assign trial = r_src + BIT;
      always_ff @(posedge clock) begin
         if (enable) begin
            if (v_src >= trial) begin
               sq_v_ff[j] <= v_src - trial;
               sq_r_ff[j] <= (r_src >> 1) + BIT;
            end else begin
               sq_v_ff[j] <= v_src;
               sq_r_ff[j] <= r_src >> 1;
            end
         end
      end
   end

   // three cordic units, all fed in the same cycle
   operand_type roll_opnd;
   assign roll_opnd.y = hc_ff[PRE_STAGES-3];
   assign roll_opnd.x = signed'({2'b00, sq_r_ff[ISQRT_STAGES-1][31:0]});

   result_type tail;

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock    (clock),
      .enable   (enable),
      .opnd_in  (pair_ff[PRE_STAGES-2].pitch),
      .angle_out(tail.pitch)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock    (clock),
      .enable   (enable),
      .opnd_in  (roll_opnd),
      .angle_out(tail.roll)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_heading (
      .clock    (clock),
      .enable   (enable),
      .opnd_in  (pair_ff[PRE_STAGES-2].heading),
      .angle_out(tail.heading)
   );

   assign tail.degen = degen_ff[TOTAL-1];

   // skid slot holds the older result while the pipeline tail moves on
   result_type skid_ff;
   result_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_ready) skid_vld_ff <= 1'b0;
      end else if (vld_ff[TOTAL-1] && !rsp_ready) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) skid_ff <= tail;
   end

   assign rsp_valid         = skid_vld_ff || vld_ff[TOTAL-1];
   assign rsp_data          = skid_vld_ff ? skid_ff : tail;
   assign rsp_pitch_angle   = rsp_data.pitch;
   assign rsp_roll_angle    = rsp_data.roll;
   assign rsp_heading_angle = rsp_data.heading;
   assign rsp_degenerate    = rsp_data.degen;

endmodule

// File: hw/rtl/qte_cordic.sv
// pipelined cordic vectoring unit: atan2 of one operand pair per cycle while enable is high
module qte_cordic #(
   parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            enable,
   input  qte_pkg::operand_type            opnd_in,
   output logic signed [qte_pkg::OUT_W-1:0] angle_out
);
   import qte_pkg::*;

   localparam int NST = STEPS + PRESCALE_PASSES + 2;

   logic signed [CORD_W-1:0] x_ff   [NST];
   logic signed [CORD_W-1:0] y_ff   [NST];
   logic        [ANG_W-1:0]  acc_ff [NST];
   logic                     zero_ff[NST];
   logic signed [CORD_W-1:0] m_ff   [PRESCALE_PASSES+1];
   logic signed [OUT_W-1:0]  angle_ff;

   logic signed [CORD_W-1:0] xe, ye, x0, y0, ya;
   logic        [ANG_W-1:0]  acc0;

   // quadrant fold into the right half plane
   always_comb begin
      xe = {{(CORD_W-OPND_W){opnd_in.x[OPND_W-1]}}, opnd_in.x};
      ye = {{(CORD_W-OPND_W){opnd_in.y[OPND_W-1]}}, opnd_in.y};
      if (xe < 0) begin
         x0   = -xe;
         y0   = -ye;
         acc0 = HALF_TURN;
      end else begin
         x0   = xe;
         y0   = ye;
         acc0 = '0;
      end
      ya = (y0 < 0) ? -y0 : y0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= x0;
         y_ff[0]    <= y0;
         acc_ff[0]  <= acc0;
         zero_ff[0] <= (xe == 0) && (ye == 0);
         m_ff[0]    <= (x0 > ya) ? x0 : ya;
      end
   end

   // binary normalize: largest magnitude brought just below the limit
   for (genvar j = 0; j < PRESCALE_PASSES; j++) begin : g_pre
      localparam int S = 1 << (PRESCALE_PASSES - 1 - j);
      localparam logic signed [CORD_W-1:0] LIM =
         {{(CORD_W-1){1'b0}}, 1'b1} << (PRESCALE_BITS - S);
      always_ff @(posedge clock) begin
         if (enable) begin
            if (m_ff[j] < LIM) begin
               x_ff[j+1] <= x_ff[j] <<< S;
               y_ff[j+1] <= y_ff[j] <<< S;
               m_ff[j+1] <= m_ff[j] <<< S;
            end else begin
               x_ff[j+1] <= x_ff[j];
               y_ff[j+1] <= y_ff[j];
               m_ff[j+1] <= m_ff[j];
            end
            acc_ff[j+1]  <= acc_ff[j];
            zero_ff[j+1] <= zero_ff[j];
         end
      end
   end

   // last doubling lifts the magnitude to the limit
   localparam logic signed [CORD_W-1:0] TOP_LIM =
      {{(CORD_W-1){1'b0}}, 1'b1} << PRESCALE_BITS;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (m_ff[PRESCALE_PASSES] < TOP_LIM) begin
            x_ff[PRESCALE_PASSES+1] <= x_ff[PRESCALE_PASSES] <<< 1;
            y_ff[PRESCALE_PASSES+1] <= y_ff[PRESCALE_PASSES] <<< 1;
         end else begin
            x_ff[PRESCALE_PASSES+1] <= x_ff[PRESCALE_PASSES];
            y_ff[PRESCALE_PASSES+1] <= y_ff[PRESCALE_PASSES];
         end
         acc_ff[PRESCALE_PASSES+1]  <= acc_ff[PRESCALE_PASSES];
         zero_ff[PRESCALE_PASSES+1] <= zero_ff[PRESCALE_PASSES];
      end
   end

   // one micro-rotation per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_rot
      localparam int SRC = PRESCALE_PASSES + 1 + k;
      logic signed [CORD_W-1:0] dx, dy;
      assign dx = y_ff[SRC] >>> k;
      assign dy = x_ff[SRC] >>> k;
      always_ff @(posedge clock) begin
         if (enable) begin
            if (y_ff[SRC] >= 0) begin
               x_ff[SRC+1]   <= x_ff[SRC] + dx;
               y_ff[SRC+1]   <= y_ff[SRC] - dy;
               acc_ff[SRC+1] <= acc_ff[SRC] + ANG_TAB[k];
            end else begin
               x_ff[SRC+1]   <= x_ff[SRC] - dx;
               y_ff[SRC+1]   <= y_ff[SRC] + dy;
               acc_ff[SRC+1] <= acc_ff[SRC] - ANG_TAB[k];
            end
            zero_ff[SRC+1] <= zero_ff[SRC];
         end
      end
   end

   logic [ANG_W-1:0] rounded;
   assign rounded = acc_ff[NST-1] + 32'h0000_8000;

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= zero_ff[NST-1] ? '0 : signed'(rounded[ANG_W-1:ANG_W-OUT_W]);
      end
   end

   assign angle_out = angle_ff;

endmodule

// File: dv/tb_quaternion_to_euler_top.sv
// testbench for the quaternion to euler converter with a behavioral cordic predictor
module tb_quaternion_to_euler_top;
   import qte_pkg::*;

   localparam int STEPS     = CORDIC_STEPS_DEF;
   localparam int LATENCY   = 37 + STEPS + 9;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic signed [15:0] heading;
      logic               degen;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_comp_w = '0, req_comp_x = '0, req_comp_y = '0, req_comp_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_pitch_angle, rsp_roll_angle, rsp_heading_angle;
   logic rsp_degenerate;

   angles_type expected_angles[$];
   int      n_errors = 0;
   int      cycle = 0;
   bit      stall_mode = 1'b0;

   always #1 clock = ~clock;

   quaternion_to_euler_top u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_comp_w, .req_comp_x, .req_comp_y,
      .req_comp_z, .rsp_valid, .rsp_ready, .rsp_pitch_angle, .rsp_roll_angle,
      .rsp_heading_angle, .rsp_degenerate
   );

   // floor shift for signed 64-bit values
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // atan2 as a 16-bit binary angle, vectoring mode
   function automatic logic [15:0] vector_angle(longint y, longint x);
      longint acc, m, dx, dy;
      acc = 0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         acc = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         x = -x;
         y = -y;
      end
      m = (y < 0) ? -y : y;
      if (x > m) m = x;
      while (m < (64'sd1 << 40)) begin
         x *= 2;
         y *= 2;
         m *= 2;
      end
      for (int i = 0; i < STEPS && i < ANG_TAB_LEN; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (y >= 0) begin
            x += dx;
            y -= dy;
            acc += longint'(ANG_TAB[i]);
         end else begin
            x -= dx;
            y += dy;
            acc -= longint'(ANG_TAB[i]);
         end
      end
      return 16'(shr_floor(acc + 32768, 16));
   endfunction

   function automatic angles_type euler_of(logic signed [15:0] qw, qx, qy, qz);
      longint w, x, y, z, sw, sx, sy, sz, n2, h, d;
      longint unsigned c;
      angles_type r;
      w = qw; x = qx; y = qy; z = qz;
      sw = w * w; sx = x * x; sy = y * y; sz = z * z;
      n2 = sw + sx + sy + sz;
      r = '0;
      if (n2 == 0) begin
         r.degen = 1'b1;
         return r;
      end
      r.pitch = vector_angle(2 * (x * y + z * w), sx - sy - sz + sw);
      h = y * w - x * z;
      d = n2 / 2;
      if (h > d) h = d;
      if (h < -d) h = -d;
      c = int_sqrt(longint'(unsigned'(d) * unsigned'(d)) - h * h);
      r.roll = vector_angle(h, longint'(c));
      r.heading = vector_angle(2 * (y * z + x * w), -sx - sy + sz + sw);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      n_errors++;
   endtask

   // one transaction on req, holds until accepted
   task automatic send_quat(logic signed [15:0] w, x, y, z);
      req_valid  <= 1'b1;
      req_comp_w <= w;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_angles.push_back(euler_of(w, x, y, z));
   endtask

   // drops valid for a random gap, or not at all to keep a burst going
   task automatic idle_gap(int max_gap);
      int g;
      g = $urandom_range(0, max_gap);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // receiver stall pattern: alternates between free running and random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
         rsp_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      angles_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_angles.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            want = expected_angles.pop_front();
            if (rsp_pitch_angle !== want.pitch)
               report_mismatch("pitch", rsp_pitch_angle, want.pitch);
            if (rsp_roll_angle !== want.roll)
               report_mismatch("roll", rsp_roll_angle, want.roll);
            if (rsp_heading_angle !== want.heading)
               report_mismatch("heading", rsp_heading_angle, want.heading);
            if (rsp_degenerate !== want.degen)
               report_mismatch("degenerate", rsp_degenerate, want.degen);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("tb: failure");
         $finish;
      end
   end

   // field extremes, zero quaternion, axes, saturated roll
   task automatic test_directed();
      logic signed [15:0] ext[4] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
      send_quat(0, 0, 0, 0);
      send_quat(16384, 0, 0, 0);
      send_quat(-16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(11585, 0, 11585, 0);
      send_quat(11585, 0, -11585, 0);
      send_quat(0, 16384, 0, 16384);
      send_quat(1, 0, 0, 0);
      for (int i = 0; i < 4; i++) begin
         send_quat(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]);
      end
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(32767, -32768, 32767, -32768);
      idle_gap(0);
   endtask

   // random quaternions, mostly full range with some small magnitudes
   task automatic test_random(int n);
      logic signed [15:0] q[4];
      int left;
      left = n;
      while (left > 0) begin
         for (int b = $urandom_range(1, 30); b > 0 && left > 0; b--) begin
            for (int k = 0; k < 4; k++) begin
               case ($urandom_range(0, 5))
                  0: q[k] = 16'($signed($urandom_range(0, 6)) - 3);
                  1: q[k] = 16'sd0;
                  default: q[k] = 16'($urandom);
               endcase
            end
            send_quat(q[0], q[1], q[2], q[3]);
            left--;
         end
         idle_gap(12);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(2000);
      waited = 0;
      while (expected_angles.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (n_errors == 0 && expected_angles.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
